[src/first_fit_block_allocator_assert.svh]
// Assertion macros for the first-fit allocator checker.
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ffba_pkg.sv]
// Shared types, constants and status codes of the first-fit block allocator.
// No dependencies; imported by the datapath, controller, top level and checker.
`default_nettype none

package ffba_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ADDR_W     = 24;
    localparam int HDR_W      = 8;
    localparam int SLOT_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = 2'd1;

    localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = 24'd65536;
    localparam logic [HDR_W-1:0]  HEADER_RESET     = 8'd16;

    localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MARKED   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd6;
    localparam logic [STATUS_W-1:0] ST_BAD_IDX  = 3'd7;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic                is_free;
        logic [ADDR_W-1:0]   start;
        logic [ADDR_W-1:0]   size;
    } entry_t;

    typedef struct packed {
        logic                latch_req;
        logic                scan_clear;
        logic                scan_issue;
        logic                free_issue;
        logic                commit;
        logic [STATUS_W-1:0] code;
        logic                load_out;
    } cmd_t;

    typedef struct packed {
        logic op_free;
        logic size_zero;
        logic bad_index;
        logic is_last;
        logic hit;
        logic scan_done;
        logic room_ok;
        logic table_full;
    } sts_t;

endpackage

`default_nettype wire

[src/first_fit_block_allocator.sv]
// Top level of the first-fit block allocator: controller plus datapath.
// Depends on ffba_pkg, ffba_ctrl and ffba_datapath.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  s_       | in        | s_valid / s_ready  | operation, request_size, target_index
//  m_       | out       | m_valid / m_ready  | status, slot_index, payload_offset, top_of_heap
//  cfg_     | in        | cfg_wr_en          | cfg_index, cfg_wr_data
//
// One request at a time. A zero size or a bad index is committed in the dispatch state; a free
// reads its target entry first; an allocate scans the table from entry 0 until a free block
// fits, which it reuses, or else appends at the heap top or fails: the first-fit scan
// reads one table entry per cycle from the single memory read port.
// s_ready rises with m_valid; a result held by m_ready stalls the next result only.
// Reset is synchronous and clears the block count and heap top; the table needs no clearing.
`default_nettype none

module first_fit_block_allocator (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ffba_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_operation,
    input  wire logic [ffba_pkg::ADDR_W-1:0]     s_request_size,
    input  wire logic [ffba_pkg::SLOT_W-1:0]     s_target_index,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [ffba_pkg::STATUS_W-1:0]        m_status,
    output logic [ffba_pkg::SLOT_W-1:0]          m_slot_index,
    output logic [ffba_pkg::ADDR_W-1:0]          m_payload_offset,
    output logic [ffba_pkg::ADDR_W-1:0]          m_top_of_heap
);
    import ffba_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ffba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ffba_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_operation      (s_operation),
        .s_request_size   (s_request_size),
        .s_target_index   (s_target_index),
        .cmd              (cmd),
        .sts              (sts),
        .m_status         (m_status),
        .m_slot_index     (m_slot_index),
        .m_payload_offset (m_payload_offset),
        .m_top_of_heap    (m_top_of_heap)
    );

endmodule

`default_nettype wire

[src/ffba_datapath.sv]
// Datapath: config registers, block table memory, scan pipeline and result registers.
// Depends on ffba_pkg; driven by ffba_ctrl through cmd_t, reports through sts_t.
`default_nettype none

module ffba_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ffba_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                            s_operation,
    input  wire logic [ffba_pkg::ADDR_W-1:0]     s_request_size,
    input  wire logic [ffba_pkg::SLOT_W-1:0]     s_target_index,
    input  wire ffba_pkg::cmd_t                  cmd,
    output ffba_pkg::sts_t                       sts,
    output logic [ffba_pkg::STATUS_W-1:0]        m_status,
    output logic [ffba_pkg::SLOT_W-1:0]          m_slot_index,
    output logic [ffba_pkg::ADDR_W-1:0]          m_payload_offset,
    output logic [ffba_pkg::ADDR_W-1:0]          m_top_of_heap
);
    import ffba_pkg::*;

    entry_t mem [MAX_BLOCKS];

    logic [ADDR_W-1:0]   heap_limit_reg;
    logic [HDR_W-1:0]    header_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   heap_top_reg, heap_top_next;

    logic                op_reg;
    logic [ADDR_W-1:0]   size_reg;
    logic [SLOT_W-1:0]   target_reg;

    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]    rd_idx_reg;
    entry_t              rd_word_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic [ADDR_W-1:0]   res_off_reg;

    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [ADDR_W-1:0]   out_off_reg, out_top_reg;

    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    entry_t              wr_data;

    logic [SLOT_W-1:0]   res_slot_next;
    logic [ADDR_W-1:0]   res_off_next;

    logic [ADDR_W+1:0]   end_sum;
    logic [ADDR_W-1:0]   hdr_ext;
    logic [CNT_W-1:0]    target_ext;
    logic                scan_more;

    assign hdr_ext    = {{(ADDR_W-HDR_W){1'b0}}, header_reg};
    assign target_ext = {{(CNT_W-SLOT_W){1'b0}}, target_reg};
    assign end_sum    = {2'b00, heap_top_reg} + {2'b00, hdr_ext} + {2'b00, size_reg};
    assign scan_more  = scan_idx_reg < count_reg;

    always_comb begin
        sts.op_free    = (op_reg == OP_FREE);
        sts.size_zero  = (size_reg == '0);
        sts.bad_index  = (target_ext >= count_reg);
        sts.is_last    = ((target_ext + 1'b1) == count_reg);
        sts.hit        = rd_valid_reg && rd_word_reg.is_free && (rd_word_reg.size >= size_reg);
        sts.scan_done  = !rd_valid_reg && !scan_more;
        sts.room_ok    = (end_sum <= {2'b00, heap_limit_reg});
        sts.table_full = (count_reg == CNT_W'(MAX_BLOCKS));
    end

    // read port: scan walks the table, free reads the target entry
    always_comb begin
        rd_en         = 1'b0;
        rd_addr       = rd_idx_reg;
        scan_idx_next = scan_idx_reg;
        rd_valid_next = 1'b0;
        if (cmd.scan_clear) begin
            scan_idx_next = '0;
        end else if (cmd.scan_issue && scan_more) begin
            rd_en         = 1'b1;
            rd_addr       = scan_idx_reg[IDX_W-1:0];
            rd_valid_next = 1'b1;
            scan_idx_next = scan_idx_reg + 1'b1;
        end
        if (cmd.free_issue) begin
            rd_en   = 1'b1;
            rd_addr = target_reg[IDX_W-1:0];
        end
    end

    // commit: table write, count and heap top update, result capture
    always_comb begin
        wr_en         = 1'b0;
        wr_addr       = rd_idx_reg;
        wr_data       = rd_word_reg;
        count_next    = count_reg;
        heap_top_next = heap_top_reg;
        res_slot_next = '0;
        res_off_next  = '0;
        if (cmd.commit) begin
            case (cmd.code)
                ST_REUSED: begin
                    wr_en           = 1'b1;
                    wr_data.is_free = 1'b0;
                    res_slot_next   = {{(SLOT_W-IDX_W){1'b0}}, rd_idx_reg};
                    res_off_next    = rd_word_reg.start + hdr_ext;
                end
                ST_NEW: begin
                    wr_en         = 1'b1;
                    wr_addr       = count_reg[IDX_W-1:0];
                    wr_data       = '{is_free: 1'b0, start: heap_top_reg, size: size_reg};
                    count_next    = count_reg + 1'b1;
                    heap_top_next = end_sum[ADDR_W-1:0];
                    res_slot_next = count_reg[SLOT_W-1:0];
                    res_off_next  = heap_top_reg + hdr_ext;
                end
                ST_MARKED: begin
                    wr_en           = 1'b1;
                    wr_addr         = target_reg[IDX_W-1:0];
                    wr_data.is_free = 1'b1;
                    res_slot_next   = target_reg;
                end
                ST_RELEASED: begin
                    wr_en           = 1'b1;
                    wr_addr         = target_reg[IDX_W-1:0];
                    wr_data.is_free = 1'b1;
                    count_next      = target_ext;
                    heap_top_next   = rd_word_reg.start;
                    res_slot_next   = target_reg;
                end
                ST_BAD_IDX: begin
                    res_slot_next = target_reg;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_limit_reg <= HEAP_LIMIT_RESET;
            header_reg     <= HEADER_RESET;
            count_reg      <= '0;
            heap_top_reg   <= '0;
            scan_idx_reg   <= '0;
            rd_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_index == REG_HEAP_LIMIT) begin
                heap_limit_reg <= cfg_wr_data[ADDR_W-1:0];
            end
            if (cfg_wr_en && cfg_index == REG_HEADER_BYTES) begin
                header_reg <= cfg_wr_data[HDR_W-1:0];
            end
            count_reg    <= count_next;
            heap_top_reg <= heap_top_next;
            scan_idx_reg <= scan_idx_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_req) begin
            op_reg     <= s_operation;
            size_reg   <= s_request_size;
            target_reg <= s_target_index;
        end
        if (rd_en) begin
            rd_idx_reg <= rd_addr;
        end
        if (cmd.commit) begin
            res_status_reg <= cmd.code;
            res_slot_reg   <= res_slot_next;
            res_off_reg    <= res_off_next;
        end
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_off_reg    <= res_off_reg;
            out_top_reg    <= heap_top_reg;
        end
    end

    assign m_status         = out_status_reg;
    assign m_slot_index     = out_slot_reg;
    assign m_payload_offset = out_off_reg;
    assign m_top_of_heap    = out_top_reg;

endmodule

`default_nettype wire

[src/ffba_ctrl.sv]
// Controller state machine: sequences accept, table scan or free, commit and output.
// Depends on ffba_pkg; talks to ffba_datapath through cmd_t and sts_t.
`default_nettype none

module ffba_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    input  wire ffba_pkg::sts_t sts,
    output ffba_pkg::cmd_t      cmd
);
    import ffba_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DISPATCH  = 3'd1;
    localparam logic [2:0] S_SCAN      = 3'd2;
    localparam logic [2:0] S_FREE_WAIT = 3'd3;
    localparam logic [2:0] S_OUT       = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.code     = ST_ZERO;
        s_ready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                cmd.scan_clear = 1'b1;
                if (!sts.op_free) begin
                    if (sts.size_zero) begin
                        cmd.commit = 1'b1;
                        cmd.code   = ST_ZERO;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_SCAN;
                    end
                end else if (sts.bad_index) begin
                    cmd.commit = 1'b1;
                    cmd.code   = ST_BAD_IDX;
                    state_next = S_OUT;
                end else begin
                    cmd.free_issue = 1'b1;
                    state_next     = S_FREE_WAIT;
                end
            end
            S_SCAN: begin
                if (sts.hit) begin
                    cmd.commit = 1'b1;
                    cmd.code   = ST_REUSED;
                    state_next = S_OUT;
                end else if (sts.scan_done) begin
                    // no free block fits: try to append at the heap top
                    cmd.commit = 1'b1;
                    if (!sts.room_ok) begin
                        cmd.code = ST_NO_ROOM;
                    end else if (sts.table_full) begin
                        cmd.code = ST_FULL;
                    end else begin
                        cmd.code = ST_NEW;
                    end
                    state_next = S_OUT;
                end else begin
                    cmd.scan_issue = 1'b1;
                end
            end
            S_FREE_WAIT: begin
                cmd.commit = 1'b1;
                cmd.code   = sts.is_last ? ST_RELEASED : ST_MARKED;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

[src/ffba_checker.sv]
// Port-level checker for the first-fit block allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator_assert.svh.
`default_nettype none

`include "first_fit_block_allocator_assert.svh"

module ffba_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic                            s_operation,
    input wire logic [ffba_pkg::ADDR_W-1:0]     s_request_size,
    input wire logic [ffba_pkg::SLOT_W-1:0]     s_target_index,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [ffba_pkg::STATUS_W-1:0]   m_status,
    input wire logic [ffba_pkg::SLOT_W-1:0]     m_slot_index,
    input wire logic [ffba_pkg::ADDR_W-1:0]     m_payload_offset,
    input wire logic [ffba_pkg::ADDR_W-1:0]     m_top_of_heap
);
    import ffba_pkg::*;

    logic [STATUS_W+SLOT_W+2*ADDR_W-1:0] out_bus;
    logic [ADDR_W+SLOT_W:0]              in_bus;
    logic                                fail_alloc;
    logic                                free_result;

    assign out_bus     = {m_status, m_slot_index, m_payload_offset, m_top_of_heap};
    assign in_bus      = {s_operation, s_request_size, s_target_index};
    assign fail_alloc  = (m_status == ST_ZERO || m_status == ST_NO_ROOM || m_status == ST_FULL);
    assign free_result = (m_status == ST_MARKED || m_status == ST_RELEASED ||
                          m_status == ST_BAD_IDX);

    // result held until its transfer
    `FFBA_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(out_bus), "result changed")

    // request held until its transfer
    `FFBA_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(in_bus), "request changed")

    // one request in flight: ready drops right after an input transfer
    `FFBA_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "second request taken")

    // failed allocations carry no slot and no offset
    `FFBA_ASSERT_NOW(a_fail_zero, m_valid && fail_alloc, m_slot_index == '0 && m_payload_offset == '0, "failed allocate")

    // free results never report a payload offset
    `FFBA_ASSERT_NOW(a_free_no_offset, m_valid && free_result, m_payload_offset == '0, "free with offset")

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

`default_nettype wire
